FILE: rtl/sbfd_pkg.sv
// Shared constants and types for the SBUS frame decoder.
`default_nettype none

package sbfd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
  localparam int CH_W         = 11;
  localparam int CNT_W        = 32;
  localparam int ACC_W        = 19;
  localparam int PEND_W       = 5;
  localparam int BCNT_W       = 5;

  localparam logic [BCNT_W-1:0] FRAME_BYTES    = BCNT_W'(25);
  localparam logic [BCNT_W-1:0] LAST_BYTE      = BCNT_W'(24);
  localparam logic [BCNT_W-1:0] COUNT_MAX      = BCNT_W'(26);
  localparam logic [BCNT_W-1:0] DATA_LAST_BYTE = BCNT_W'(22);
  localparam logic [BCNT_W-1:0] FLAG_BYTE      = BCNT_W'(23);

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE = 8'h00;
  localparam int         FAILSAFE_POS = 3;
  localparam int         LOST_POS     = 2;

  localparam logic [PEND_W-1:0] BYTE_BITS = PEND_W'(8);
  localparam logic [PEND_W-1:0] CH_BITS   = PEND_W'(CH_W);
  localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_WRONG_LENGTH = 2'd1,
    STATUS_BAD_FRAME    = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/sbfd_byte_if.sv
// Byte channel into the decoder: valid/ready plus one received byte.
`default_nettype none

interface sbfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       frame_end;

  modport source (output valid, output byte_value, output frame_end, input ready);
  modport sink   (input valid, input byte_value, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbfd_result_if.sv
// Result channel out of the decoder: valid/ready plus one decoded result.
`default_nettype none

interface sbfd_result_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [sbfd_pkg::CH_IDX_W-1:0] channel_index;
  logic [sbfd_pkg::CH_W-1:0]   channel_value;
  logic                        failsafe_flag;
  logic                        lost_frame_flag;
  logic                        frame_fresh;
  logic [sbfd_pkg::CNT_W-1:0]  success_count;
  logic [sbfd_pkg::CNT_W-1:0]  fail_count;
  logic                        last_of_frame;

  modport source (
    output valid, output status, output channel_index, output channel_value,
    output failsafe_flag, output lost_frame_flag, output frame_fresh,
    output success_count, output fail_count, output last_of_frame,
    input ready
  );
  modport sink (
    input valid, input status, input channel_index, input channel_value,
    input failsafe_flag, input lost_frame_flag, input frame_fresh,
    input success_count, input fail_count, input last_of_frame,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/sbus_frame_decoder_unit.sv
// Top level of the SBUS frame decoder: unpacking, frame checks and result burst.
`default_nettype none

// Usage:
//   rx_byte carries one received byte per transaction, with frame_end set on
//   the last byte before line idle. result carries decoded results.
//   Bytes 1..22 are unpacked as they arrive; each completed 11-bit channel is
//   written into a 16-entry staging memory (one write per byte at most).
//   A byte without frame_end gives no result.
//   At frame end the block gives one status transaction (wrong length, or bad
//   header/footer), registered in the cycle after the byte is accepted, or a
//   burst of sixteen channel transactions read back from the staging memory.
//   In the burst each channel is read from the staging memory, whose read
//   data is registered, then loaded into the output register; the next read
//   waits for that load, and no byte is taken until the burst ends.
//   rx_byte.ready is high outside the burst while the output register is free
//   or being taken in the same cycle.
//   When the receiver stalls, the output register holds its result and no new
//   memory read is issued until it drains.
//   Reset (rst, synchronous) clears byte count, accumulator, flags, counters
//   and the output valid; the staging memory is not cleared, since a good
//   frame writes every entry before it is read.

module sbus_frame_decoder_unit (
  input wire logic      clk,
  input wire logic      rst,
  sbfd_byte_if.sink     rx_byte,
  sbfd_result_if.source result
);

  typedef enum logic {
    ST_RUN,
    ST_BURST
  } state_t;

  state_t state;

  // Frame assembly state.
  logic [sbfd_pkg::BCNT_W-1:0]   byte_count;
  logic [sbfd_pkg::ACC_W-1:0]    bit_acc;
  logic [sbfd_pkg::PEND_W-1:0]   pending_bits;
  logic [sbfd_pkg::CH_IDX_W-1:0] wr_ch;
  logic                          header_good;
  logic                          failsafe;
  logic                          lost_frame;
  logic [sbfd_pkg::CNT_W-1:0]    good_frames;
  logic [sbfd_pkg::CNT_W-1:0]    bad_frames;

  // Burst readout state.
  logic [sbfd_pkg::CH_IDX_W-1:0] rd_idx;
  logic [sbfd_pkg::CH_IDX_W-1:0] rd_ch;
  logic                          rd_pending;
  logic [sbfd_pkg::CH_W-1:0]     rd_data;

  // Output register.
  logic                          out_valid;
  sbfd_pkg::status_t             out_status;
  logic [sbfd_pkg::CH_IDX_W-1:0] out_index;
  logic [sbfd_pkg::CH_W-1:0]     out_value;
  logic                          out_fs;
  logic                          out_lost;
  logic                          out_fresh;
  logic [sbfd_pkg::CNT_W-1:0]    out_success;
  logic [sbfd_pkg::CNT_W-1:0]    out_fail;
  logic                          out_last;

  logic                          out_free;
  logic                          in_ready;
  logic                          in_accept;
  logic                          rd_issue;

  logic                          data_byte;
  logic [sbfd_pkg::ACC_W-1:0]    acc_sum;
  logic [sbfd_pkg::PEND_W-1:0]   pend_sum;
  logic                          ch_done;
  logic                          mem_we;

  assign out_free  = !out_valid || result.ready;
  assign in_ready  = (state == ST_RUN) && out_free;
  assign in_accept = rx_byte.valid && in_ready;
  assign rd_issue  = (state == ST_BURST) && !rd_pending && out_free;

  // Merge the byte above the bits already pending, LSB first.
  always_comb begin
    data_byte = (byte_count != '0) && (byte_count <= sbfd_pkg::DATA_LAST_BYTE);
    acc_sum   = bit_acc | (sbfd_pkg::ACC_W'(rx_byte.byte_value) << pending_bits);
    pend_sum  = pending_bits + sbfd_pkg::BYTE_BITS;
    ch_done   = pend_sum >= sbfd_pkg::CH_BITS;
    mem_we    = in_accept && data_byte && ch_done;
  end

  sbfd_chan_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ch),
    .wdata (acc_sum[sbfd_pkg::CH_W-1:0]),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      byte_count   <= '0;
      bit_acc      <= '0;
      pending_bits <= '0;
      wr_ch        <= '0;
      header_good  <= 1'b0;
      failsafe     <= 1'b0;
      lost_frame   <= 1'b0;
      good_frames  <= '0;
      bad_frames   <= '0;
      rd_idx       <= '0;
      rd_ch        <= '0;
      rd_pending   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_RUN: begin
          if (in_accept) begin
            if (byte_count < sbfd_pkg::COUNT_MAX) begin
              byte_count <= byte_count + 1'b1;
            end

            if (byte_count == '0) begin
              header_good <= (rx_byte.byte_value == sbfd_pkg::HEADER_BYTE);
            end else if (data_byte) begin
              if (ch_done) begin
                // Drop the channel just written and advance the write slot.
                bit_acc      <= acc_sum >> sbfd_pkg::CH_W;
                pending_bits <= pend_sum - sbfd_pkg::CH_BITS;
                wr_ch        <= wr_ch + 1'b1;
              end else begin
                bit_acc      <= acc_sum;
                pending_bits <= pend_sum;
              end
            end else if (byte_count == sbfd_pkg::FLAG_BYTE) begin
              failsafe   <= rx_byte.byte_value[sbfd_pkg::FAILSAFE_POS];
              lost_frame <= rx_byte.byte_value[sbfd_pkg::LOST_POS];
            end

            if (rx_byte.frame_end) begin
              byte_count   <= '0;
              bit_acc      <= '0;
              pending_bits <= '0;
              wr_ch        <= '0;
              out_index    <= '0;
              out_value    <= '0;
              out_fs       <= 1'b0;
              out_lost     <= 1'b0;
              out_fresh    <= 1'b0;
              out_last     <= 1'b1;
              if (byte_count != sbfd_pkg::LAST_BYTE) begin
                out_valid   <= 1'b1;
                out_status  <= sbfd_pkg::STATUS_WRONG_LENGTH;
                out_success <= good_frames;
                out_fail    <= bad_frames;
              end else if (!header_good ||
                           rx_byte.byte_value != sbfd_pkg::FOOTER_BYTE) begin
                bad_frames  <= bad_frames + 1'b1;
                out_valid   <= 1'b1;
                out_status  <= sbfd_pkg::STATUS_BAD_FRAME;
                out_success <= good_frames;
                out_fail    <= bad_frames + 1'b1;
              end else begin
                good_frames <= good_frames + 1'b1;
                rd_idx      <= '0;
                state       <= ST_BURST;
              end
            end
          end
        end

        ST_BURST: begin
          if (rd_issue) begin
            rd_ch      <= rd_idx;
            rd_idx     <= rd_idx + 1'b1;
            rd_pending <= 1'b1;
          end
          if (rd_pending) begin
            // Read data is valid now; the output was freed when it was issued.
            rd_pending  <= 1'b0;
            out_valid   <= 1'b1;
            out_status  <= sbfd_pkg::STATUS_OK;
            out_index   <= rd_ch;
            out_value   <= rd_data;
            out_fs      <= failsafe;
            out_lost    <= lost_frame;
            out_fresh   <= !failsafe && !lost_frame;
            out_success <= good_frames;
            out_fail    <= bad_frames;
            out_last    <= (rd_ch == sbfd_pkg::LAST_CH);
            if (rd_ch == sbfd_pkg::LAST_CH) begin
              state <= ST_RUN;
            end
          end
        end

        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  assign rx_byte.ready          = in_ready;
  assign result.valid           = out_valid;
  assign result.status          = out_status;
  assign result.channel_index   = out_index;
  assign result.channel_value   = out_value;
  assign result.failsafe_flag   = out_fs;
  assign result.lost_frame_flag = out_lost;
  assign result.frame_fresh     = out_fresh;
  assign result.success_count   = out_success;
  assign result.fail_count      = out_fail;
  assign result.last_of_frame   = out_last;

endmodule

`default_nettype wire

FILE: rtl/sbfd_chan_store.sv
// Channel staging memory: one write port, one read port, registered read data.
`default_nettype none

module sbfd_chan_store (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [sbfd_pkg::CH_IDX_W-1:0] waddr,
  input  wire logic [sbfd_pkg::CH_W-1:0]     wdata,
  input  wire logic [sbfd_pkg::CH_IDX_W-1:0] raddr,
  output      logic [sbfd_pkg::CH_W-1:0]     rdata
);

  logic [sbfd_pkg::CH_W-1:0] mem [sbfd_pkg::NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
